@@ rtl/core/crsv_pkg.sv @@
// shared types, constants and defaults for the contour row span voxelizer
// used by every module under rtl/core but crsv_ram
package crsv_pkg;

    localparam int MAX_SLICES_DEF      = 64;
    localparam int MAX_ROWS_DEF        = 256;
    localparam int COORD_FRAC_BITS_DEF = 16;

    localparam int CMD_W      = 2;
    localparam int COORD_W    = 17;
    localparam int SLICE_SEL_W = 6;
    localparam int ROW_SEL_W  = 8;
    localparam int COL_W      = 10;
    localparam int COLS_W     = 11;
    localparam int ROWS_W     = 9;
    localparam int SLICES_W   = 11;
    localparam int CONTOUR_W  = 7;
    localparam int POINTS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [COL_W-1:0]    COL_CAP     = 10'd1023;
    localparam logic [POINTS_W-1:0] POINTS_FULL = 2'd3;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLUMNS  = 2'd0,
        CFG_ROWS     = 2'd1,
        CFG_SLICES   = 2'd2,
        CFG_CONTOURS = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QZ,
        ST_QY,
        ST_QX,
        ST_UPD,
        ST_RD0,
        ST_RD1
    } state_t;

    typedef enum logic [1:0] {
        MUL_Z,
        MUL_Y,
        MUL_X
    } mul_sel_t;

    typedef struct packed {
        logic     load_in;
        mul_sel_t mul_sel;
        logic     load_k;
        logic     load_row;
        logic     load_col;
        logic     slice_rd;
        logic     slice_wr;
        logic     row_rd;
        logic     row_wr;
        logic     clr_wr;
        logic     rd_issue;
        logic     out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic slice_ok;
        logic row_ok;
        logic clr_last;
        logic out_free;
    } ctrl_stat_t;

    typedef struct packed {
        logic             seen;
        logic [COL_W-1:0] min_col;
        logic [COL_W-1:0] max_col;
    } row_entry_t;

endpackage

@@ rtl/core/contour_row_span_voxelizer.sv @@
// add point: one shared multiplier quantizes z, y, x in turn, then a row
//   read-modify-write follows; ends early on an unknown slice or on a row off the mask
// read span: the ram read is issued, then the result is loaded into the output register;
//   the next accept waits while the previous result beat sits stalled; an unused command frees the input next cycle
// clear and reset: clearing pass over all MAX_SLICES*MAX_ROWS row entries (16384 by
//   default) and the slice counts, input stalled meanwhile; config writes taken at any time
module contour_row_span_voxelizer #(
    parameter int MAX_SLICES      = crsv_pkg::MAX_SLICES_DEF,
    parameter int MAX_ROWS        = crsv_pkg::MAX_ROWS_DEF,
    parameter int COORD_FRAC_BITS = crsv_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [crsv_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [crsv_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [crsv_pkg::CMD_W-1:0]       command,
    input  logic [crsv_pkg::COORD_W-1:0]     x_coord,
    input  logic [crsv_pkg::COORD_W-1:0]     y_coord,
    input  logic [crsv_pkg::COORD_W-1:0]     z_coord,
    input  logic [crsv_pkg::SLICE_SEL_W-1:0] slice_sel,
    input  logic [crsv_pkg::ROW_SEL_W-1:0]   row_sel,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [crsv_pkg::COL_W-1:0]       span_left,
    output logic [crsv_pkg::COL_W-1:0]       span_right,
    output logic                             span_fill
);

    crsv_pkg::ctrl_cmd_t  ctrl;
    crsv_pkg::ctrl_stat_t stat;

    crsv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .in_stall (in_stall),
        .ctrl     (ctrl),
        .stat     (stat)
    );

    crsv_dpath #(
        .MAX_SLICES      (MAX_SLICES),
        .MAX_ROWS        (MAX_ROWS),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .x_coord    (x_coord),
        .y_coord    (y_coord),
        .z_coord    (z_coord),
        .slice_sel  (slice_sel),
        .row_sel    (row_sel),
        .ctrl       (ctrl),
        .stat       (stat),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .span_left  (span_left),
        .span_right (span_right),
        .span_fill  (span_fill)
    );

endmodule

@@ rtl/core/crsv_ram.sv @@
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module crsv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/crsv_ctrl.sv @@
// sequencing state machine: clearing pass, point update and span read steps
// depends on crsv_pkg
module crsv_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [crsv_pkg::CMD_W-1:0] command,
    output logic                       in_stall,
    output crsv_pkg::ctrl_cmd_t        ctrl,
    input  crsv_pkg::ctrl_stat_t       stat
);

    crsv_pkg::state_t state_reg;
    crsv_pkg::state_t state_next;
    crsv_pkg::cmd_t   cmd_in;

    assign cmd_in   = crsv_pkg::cmd_t'(command);
    assign in_stall = (state_reg != crsv_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= crsv_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        unique case (state_reg)
            crsv_pkg::ST_CLEAR:
            begin
                ctrl.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = crsv_pkg::ST_IDLE;
                end
            end
            crsv_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.load_in = 1'b1;
                    unique case (cmd_in)
                        crsv_pkg::CMD_CLEAR: state_next = crsv_pkg::ST_CLEAR;
                        crsv_pkg::CMD_ADD:   state_next = crsv_pkg::ST_QZ;
                        crsv_pkg::CMD_READ:  state_next = crsv_pkg::ST_RD0;
                        crsv_pkg::CMD_NONE:  state_next = crsv_pkg::ST_IDLE;
                    endcase
                end
            end
            crsv_pkg::ST_QZ:
            begin
                ctrl.mul_sel = crsv_pkg::MUL_Z;
                ctrl.load_k  = 1'b1;
                state_next   = crsv_pkg::ST_QY;
            end
            crsv_pkg::ST_QY:
            begin
                ctrl.mul_sel  = crsv_pkg::MUL_Y;
                ctrl.load_row = 1'b1;
                if (stat.slice_ok)
                begin
                    ctrl.slice_rd = 1'b1;
                    state_next    = crsv_pkg::ST_QX;
                end
                else
                begin
                    state_next = crsv_pkg::ST_IDLE;
                end
            end
            crsv_pkg::ST_QX:
            begin
                ctrl.mul_sel  = crsv_pkg::MUL_X;
                ctrl.load_col = 1'b1;
                ctrl.slice_wr = 1'b1;
                if (stat.row_ok)
                begin
                    ctrl.row_rd = 1'b1;
                    state_next  = crsv_pkg::ST_UPD;
                end
                else
                begin
                    state_next = crsv_pkg::ST_IDLE;
                end
            end
            crsv_pkg::ST_UPD:
            begin
                ctrl.row_wr = 1'b1;
                state_next  = crsv_pkg::ST_IDLE;
            end
            crsv_pkg::ST_RD0:
            begin
                ctrl.rd_issue = 1'b1;
                state_next    = crsv_pkg::ST_RD1;
            end
            crsv_pkg::ST_RD1:
            begin
                // ram read data holds until the output register frees up
                if (stat.out_free)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = crsv_pkg::ST_IDLE;
                end
            end
        endcase
    end

    a_load_needs_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_load |-> stat.out_free)
        else $error("result loaded while output register busy");

    a_add_starts_quant: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && cmd_in == crsv_pkg::CMD_ADD) |=>
        state_reg == crsv_pkg::ST_QZ)
        else $error("add beat did not start quantization");

    a_row_wr_after_qx: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.row_wr |-> $past(state_reg) == crsv_pkg::ST_QX)
        else $error("row write without preceding row read");

    a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == crsv_pkg::ST_CLEAR && stat.clr_last) |=>
        state_reg == crsv_pkg::ST_IDLE)
        else $error("clearing pass did not end at last entry");

endmodule

@@ rtl/core/crsv_dpath.sv @@
// datapath: config registers, shared quantizer multiplier, row and slice
// memories, clear counters and output register; depends on crsv_pkg, crsv_ram
module crsv_dpath #(
    parameter int MAX_SLICES      = crsv_pkg::MAX_SLICES_DEF,
    parameter int MAX_ROWS        = crsv_pkg::MAX_ROWS_DEF,
    parameter int COORD_FRAC_BITS = crsv_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [crsv_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [crsv_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [crsv_pkg::COORD_W-1:0]     x_coord,
    input  logic [crsv_pkg::COORD_W-1:0]     y_coord,
    input  logic [crsv_pkg::COORD_W-1:0]     z_coord,
    input  logic [crsv_pkg::SLICE_SEL_W-1:0] slice_sel,
    input  logic [crsv_pkg::ROW_SEL_W-1:0]   row_sel,
    input  crsv_pkg::ctrl_cmd_t              ctrl,
    output crsv_pkg::ctrl_stat_t             stat,
    input  logic                             out_stall,
    output logic                             out_valid,
    output logic [crsv_pkg::COL_W-1:0]       span_left,
    output logic [crsv_pkg::COL_W-1:0]       span_right,
    output logic                             span_fill
);

    localparam int SW    = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int DEPTH = MAX_SLICES * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = crsv_pkg::COORD_W + crsv_pkg::COLS_W;
    localparam int QW    = PW + 1 - COORD_FRAC_BITS;
    localparam int EW    = $bits(crsv_pkg::row_entry_t);
    localparam logic [PW:0]   HALF      = (PW + 1)'(1) << (COORD_FRAC_BITS - 1);
    localparam logic [SW-1:0] SLICE_END = SW'(MAX_SLICES - 1);
    localparam logic [RW-1:0] ROW_END   = RW'(MAX_ROWS - 1);

    // configuration
    logic [crsv_pkg::COLS_W-1:0]    cols_reg;
    logic [crsv_pkg::ROWS_W-1:0]    rows_reg;
    logic [crsv_pkg::SLICES_W-1:0]  slices_reg;
    logic [crsv_pkg::CONTOUR_W-1:0] contours_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg     <= '0;
            rows_reg     <= '0;
            slices_reg   <= '0;
            contours_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (crsv_pkg::cfg_idx_t'(cfg_index))
                crsv_pkg::CFG_COLUMNS:  cols_reg     <= cfg_data;
                crsv_pkg::CFG_ROWS:     rows_reg     <= crsv_pkg::ROWS_W'(cfg_data);
                crsv_pkg::CFG_SLICES:   slices_reg   <= cfg_data;
                crsv_pkg::CFG_CONTOURS: contours_reg <= crsv_pkg::CONTOUR_W'(cfg_data);
            endcase
        end
    end

    // input beat
    logic [crsv_pkg::COORD_W-1:0]     x_reg;
    logic [crsv_pkg::COORD_W-1:0]     y_reg;
    logic [crsv_pkg::COORD_W-1:0]     z_reg;
    logic [crsv_pkg::SLICE_SEL_W-1:0] slice_sel_reg;
    logic [crsv_pkg::ROW_SEL_W-1:0]   row_sel_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load_in)
        begin
            x_reg         <= x_coord;
            y_reg         <= y_coord;
            z_reg         <= z_coord;
            slice_sel_reg <= slice_sel;
            row_sel_reg   <= row_sel;
        end
    end

    // one quantizer multiplier shared over the three axes
    logic [crsv_pkg::COORD_W-1:0] mul_a;
    logic [crsv_pkg::COLS_W-1:0]  mul_b;
    logic [PW-1:0]                product;
    logic [PW:0]                  rounded;
    logic [QW-1:0]                quant;
    logic [QW-1:0]                k_reg;
    logic [QW-1:0]                row_q_reg;
    logic [QW-1:0]                col_q_reg;

    always_comb
    begin
        unique case (ctrl.mul_sel)
            crsv_pkg::MUL_Z:
            begin
                mul_a = z_reg;
                mul_b = slices_reg;
            end
            crsv_pkg::MUL_Y:
            begin
                mul_a = y_reg;
                mul_b = crsv_pkg::COLS_W'(rows_reg);
            end
            crsv_pkg::MUL_X:
            begin
                mul_a = x_reg;
                mul_b = cols_reg;
            end
            default:
            begin
                mul_a = x_reg;
                mul_b = cols_reg;
            end
        endcase
    end

    assign product = PW'(mul_a) * PW'(mul_b);
    assign rounded = (PW + 1)'(product) + HALF;
    assign quant   = rounded[PW:COORD_FRAC_BITS];

    always_ff @(posedge clk)
    begin
        if (ctrl.load_k)
        begin
            k_reg <= quant;
        end
        if (ctrl.load_row)
        begin
            row_q_reg <= quant;
        end
        if (ctrl.load_col)
        begin
            col_q_reg <= quant;
        end
    end

    // point addressing and range checks
    logic [SW-1:0] slice_add;
    logic [RW-1:0] row_add;
    logic [AW-1:0] idx_add;

    assign slice_add = SW'(k_reg - QW'(1));
    assign row_add   = RW'(row_q_reg);
    assign idx_add   = AW'(slice_add) * AW'(MAX_ROWS) + AW'(row_add);

    assign stat.slice_ok = (k_reg != '0)
                        && (32'(k_reg) <= 32'(contours_reg))
                        && (32'(k_reg) <= 32'(slices_reg))
                        && (32'(k_reg) <= 32'(MAX_SLICES));
    assign stat.row_ok   = (32'(row_q_reg) < 32'(rows_reg))
                        && (32'(row_q_reg) < 32'(MAX_ROWS));

    // column saturation to the mask width and the 10-bit cap
    logic [crsv_pkg::COLS_W-1:0] col_sat;
    logic [crsv_pkg::COL_W-1:0]  col_fin;

    always_comb
    begin
        if (cols_reg == '0)
        begin
            col_sat = '0;
        end
        else if (32'(col_q_reg) >= 32'(cols_reg))
        begin
            col_sat = cols_reg - crsv_pkg::COLS_W'(1);
        end
        else
        begin
            col_sat = crsv_pkg::COLS_W'(col_q_reg);
        end
        if (col_sat > crsv_pkg::COLS_W'(crsv_pkg::COL_CAP))
        begin
            col_fin = crsv_pkg::COL_CAP;
        end
        else
        begin
            col_fin = crsv_pkg::COL_W'(col_sat);
        end
    end

    // read addressing
    logic [SW-1:0] slice_rd;
    logic [AW-1:0] idx_rd;
    logic          rd_ok;
    logic          rd_ok_reg;

    assign slice_rd = SW'(slice_sel_reg);
    assign idx_rd   = AW'(slice_rd) * AW'(MAX_ROWS) + AW'(RW'(row_sel_reg));
    assign rd_ok    = (cols_reg != '0) && (rows_reg != '0)
                   && (32'(row_sel_reg) < 32'(rows_reg))
                   && (32'(row_sel_reg) < 32'(MAX_ROWS))
                   && (32'(slice_sel_reg) < 32'(contours_reg))
                   && (32'(slice_sel_reg) < 32'(slices_reg))
                   && (32'(slice_sel_reg) < 32'(MAX_SLICES));

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_issue)
        begin
            rd_ok_reg <= rd_ok;
        end
    end

    // clearing pass counters, row inner and slice outer
    logic [SW-1:0] clr_slice_reg;
    logic [RW-1:0] clr_row_reg;
    logic [AW-1:0] idx_clr;

    assign idx_clr       = AW'(clr_slice_reg) * AW'(MAX_ROWS) + AW'(clr_row_reg);
    assign stat.clr_last = (clr_slice_reg == SLICE_END) && (clr_row_reg == ROW_END);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_slice_reg <= '0;
            clr_row_reg   <= '0;
        end
        else if (ctrl.clr_wr)
        begin
            if (clr_row_reg == ROW_END)
            begin
                clr_row_reg <= '0;
                if (clr_slice_reg == SLICE_END)
                begin
                    clr_slice_reg <= '0;
                end
                else
                begin
                    clr_slice_reg <= clr_slice_reg + SW'(1);
                end
            end
            else
            begin
                clr_row_reg <= clr_row_reg + RW'(1);
            end
        end
    end

    // slice point counts
    logic [crsv_pkg::POINTS_W-1:0] pts_rdata;
    logic [crsv_pkg::POINTS_W-1:0] pts_next;
    logic                          pts_we;
    logic [SW-1:0]                 pts_waddr;
    logic [crsv_pkg::POINTS_W-1:0] pts_wdata;
    logic                          pts_re;
    logic [SW-1:0]                 pts_raddr;

    assign pts_next  = (pts_rdata == crsv_pkg::POINTS_FULL) ? pts_rdata
                     : pts_rdata + crsv_pkg::POINTS_W'(1);
    assign pts_we    = ctrl.slice_wr || ctrl.clr_wr;
    assign pts_waddr = ctrl.clr_wr ? clr_slice_reg : slice_add;
    assign pts_wdata = ctrl.clr_wr ? '0 : pts_next;
    assign pts_re    = ctrl.slice_rd || ctrl.rd_issue;
    assign pts_raddr = ctrl.rd_issue ? slice_rd : slice_add;

    crsv_ram #(
        .WIDTH (crsv_pkg::POINTS_W),
        .DEPTH (MAX_SLICES),
        .AW    (SW)
    ) u_pts_ram (
        .clk   (clk),
        .we    (pts_we),
        .waddr (pts_waddr),
        .wdata (pts_wdata),
        .re    (pts_re),
        .raddr (pts_raddr),
        .rdata (pts_rdata)
    );

    // row entries: seen flag with min and max column
    crsv_pkg::row_entry_t row_rdata;
    crsv_pkg::row_entry_t row_next;
    crsv_pkg::row_entry_t row_wdata;
    logic [EW-1:0]        row_rdata_raw;
    logic                 row_we;
    logic [AW-1:0]        row_waddr;
    logic                 row_re;
    logic [AW-1:0]        row_raddr;

    assign row_rdata = crsv_pkg::row_entry_t'(row_rdata_raw);

    always_comb
    begin
        row_next.seen = 1'b1;
        if (!row_rdata.seen)
        begin
            row_next.min_col = col_fin;
            row_next.max_col = col_fin;
        end
        else
        begin
            row_next.min_col = (col_fin < row_rdata.min_col) ? col_fin : row_rdata.min_col;
            row_next.max_col = (col_fin > row_rdata.max_col) ? col_fin : row_rdata.max_col;
        end
    end

    assign row_we    = ctrl.row_wr || ctrl.clr_wr;
    assign row_waddr = ctrl.clr_wr ? idx_clr : idx_add;
    assign row_wdata = ctrl.clr_wr ? '0 : row_next;
    assign row_re    = ctrl.row_rd || ctrl.rd_issue;
    assign row_raddr = ctrl.rd_issue ? idx_rd : idx_add;

    crsv_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .re    (row_re),
        .raddr (row_raddr),
        .rdata (row_rdata_raw)
    );

    // output register
    logic                       fill;
    logic                       out_valid_reg;
    logic [crsv_pkg::COL_W-1:0] left_reg;
    logic [crsv_pkg::COL_W-1:0] right_reg;
    logic                       fill_reg;

    assign fill          = rd_ok_reg && (pts_rdata == crsv_pkg::POINTS_FULL) && row_rdata.seen;
    assign stat.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            left_reg  <= fill ? row_rdata.min_col : '0;
            right_reg <= fill ? row_rdata.max_col : '0;
            fill_reg  <= fill;
        end
    end

    assign out_valid  = out_valid_reg;
    assign span_left  = left_reg;
    assign span_right = right_reg;
    assign span_fill  = fill_reg;

endmodule
